### src/md5_pkg.sv
// Package for the MD5 digest core: constants, beat structs, round helpers.
// No dependencies.
package md5_pkg;

  localparam int WORD_W   = 32;
  localparam int PREFIX_W = 40;
  localparam int COUNT_W  = 61;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WORD_W-1:0] IV_A_RST = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B_RST = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C_RST = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D_RST = 32'h10325476;

  localparam logic [CFG_IDX_W-1:0] REG_IV_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IV_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 3'd4;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_a;
    logic [WORD_W-1:0] digest_b;
    logic [WORD_W-1:0] digest_c;
    logic [WORD_W-1:0] digest_d;
  } out_beat_t;

  // Front-to-back command: one byte, or an end of message.
  typedef struct packed {
    logic       has_byte;
    logic       last;
    logic       fresh;
    logic [7:0] data_byte;
  } cmd_t;

  function automatic logic [WORD_W-1:0] add_const(input logic [5:0] i);
    logic [WORD_W-1:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

### src/md5_stream_if.sv
// Valid/ready channel interface carrying one payload type.
// No package dependency; the payload type is a parameter.
interface md5_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/md5_front.sv
// Front end: drops empty beats, tags the first beat of each message,
// and queues commands for the compression engine. Depends on md5_pkg.
module md5_front #(
  parameter int QueueDepth = md5_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  md5_pkg::in_beat_t in_data,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output md5_pkg::cmd_t  cmd_data
);
  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW:0] QFull = QueueDepth[PtrW:0];

  md5_pkg::cmd_t     queue_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]     fill_r;
  logic              fresh_r;
  logic              push, pop, useful;

  assign useful    = in_data.has_byte | in_data.last;
  assign in_ready  = (fill_r != QFull);
  assign push      = in_valid & in_ready & useful;
  assign cmd_valid = (fill_r != '0);
  assign pop       = cmd_valid & cmd_ready;
  assign cmd_data  = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{has_byte: in_data.has_byte, last: in_data.last,
                             fresh: fresh_r, data_byte: in_data.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      fresh_r  <= 1'b1;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
        fresh_r  <= in_data.last;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end
endmodule

### src/md5_back.sv
// Back end: packs bytes into the block, pads, runs 64 MD5 rounds one per
// cycle and holds the digest in an output register. Depends on md5_pkg.
module md5_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  md5_pkg::cmd_t                cmd_data,
  input  logic [md5_pkg::WORD_W-1:0]   iv_a,
  input  logic [md5_pkg::WORD_W-1:0]   iv_b,
  input  logic [md5_pkg::WORD_W-1:0]   iv_c,
  input  logic [md5_pkg::WORD_W-1:0]   iv_d,
  input  logic [md5_pkg::PREFIX_W-1:0] prefix_bytes,
  output logic                         out_valid,
  input  logic                         out_ready,
  output md5_pkg::out_beat_t           out_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;  // take a command
  localparam logic [2:0] ST_PAD  = 3'd1;  // zero-fill words after the 0x80
  localparam logic [2:0] ST_LEN  = 3'd2;  // write length words
  localparam logic [2:0] ST_RND  = 3'd3;  // compression rounds
  localparam logic [2:0] ST_ADD  = 3'd4;  // fold into chain
  localparam logic [2:0] ST_OUT  = 3'd5;  // wait for output register

  logic [2:0]  state_r;
  logic [31:0] blk_r [16];
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic [60:0] cnt_r;
  logic [3:0]  pad_w_r;     // next word to zero
  logic        final_r;     // compression belongs to the closing block
  logic        extra_r;     // another padding block follows this compression
  logic        obuf_v_r;
  md5_pkg::out_beat_t obuf_r;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [1:0]  bsel;
  logic [31:0] fval, sum, rot, blkw;
  logic [3:0]  g;
  logic [1:0]  rgrp;
  logic [4:0]  sh;
  logic [63:0] bits;
  logic [60:0] pad_add;
  logic [60:0] total;

  assign pos  = cnt_r[5:0];
  assign wsel = pos[5:2];
  assign bsel = pos[1:0];
  assign rgrp = rnd_r[5:4];

  always_comb begin
    case (rgrp)
      2'd0: begin fval = (b_r & c_r) | (~b_r & d_r); g = rnd_r[3:0]; end
      2'd1: begin
        fval = (b_r & d_r) | (c_r & ~d_r);
        g = 4'(({2'b0, rnd_r[3:0]} * 6'd5) + 6'd1);
      end
      2'd2: begin fval = b_r ^ c_r ^ d_r; g = 4'(({2'b0, rnd_r[3:0]} * 6'd3) + 6'd5); end
      default: begin fval = c_r ^ (b_r | ~d_r); g = 4'({2'b0, rnd_r[3:0]} * 6'd7); end
    endcase
  end

  assign blkw = blk_r[g];
  assign sum  = a_r + fval + md5_pkg::add_const(rnd_r) + blkw;
  assign sh   = md5_pkg::rot_amount({rgrp, rnd_r[1:0]});
  assign rot  = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  // padded size of the prefix: p + ((55 - p) mod 64) + 9, or 0 when p is 0
  assign pad_add = (prefix_bytes == '0) ? '0 :
                   61'(prefix_bytes) + 61'(6'(6'd55 - prefix_bytes[5:0])) + 61'd9;
  assign total = cnt_r + pad_add;
  assign bits  = {total, 3'b000};

  assign cmd_ready = (state_r == ST_IDLE);
  assign out_valid = obuf_v_r;
  assign out_data  = obuf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      obuf_v_r <= 1'b0;
      rnd_r    <= '0;
      final_r  <= 1'b0;
      extra_r  <= 1'b0;
      pad_w_r  <= '0;
      ch_r[0]  <= md5_pkg::IV_A_RST;
      ch_r[1]  <= md5_pkg::IV_B_RST;
      ch_r[2]  <= md5_pkg::IV_C_RST;
      ch_r[3]  <= md5_pkg::IV_D_RST;
    end else begin
      if (obuf_v_r && out_ready) obuf_v_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            logic [60:0] c;
            logic [5:0]  p;
            c = cmd_data.fresh ? '0 : cnt_r;
            if (cmd_data.fresh) begin
              ch_r[0] <= iv_a; ch_r[1] <= iv_b; ch_r[2] <= iv_c; ch_r[3] <= iv_d;
            end
            p = c[5:0];
            if (cmd_data.has_byte) begin
              if (p[1:0] == 2'd0) blk_r[p[5:2]] <= {24'd0, cmd_data.data_byte};
              else blk_r[p[5:2]][8*p[1:0] +: 8] <= cmd_data.data_byte;
              c = c + 61'd1;
            end
            cnt_r <= c;
            final_r <= 1'b0;
            if (cmd_data.has_byte && p == 6'd63) begin
              extra_r <= cmd_data.last;
              rnd_r <= '0;
              a_r <= cmd_data.fresh ? iv_a : ch_r[0];
              b_r <= cmd_data.fresh ? iv_b : ch_r[1];
              c_r <= cmd_data.fresh ? iv_c : ch_r[2];
              d_r <= cmd_data.fresh ? iv_d : ch_r[3];
              state_r <= ST_RND;
            end else if (cmd_data.last) begin
              state_r <= ST_PAD;
              pad_w_r <= '0;
              extra_r <= 1'b1;
            end else begin
              extra_r <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          // place 0x80 at pos, clear words after it
          if (pad_w_r == '0) begin
            if (bsel == 2'd0) blk_r[wsel] <= {24'd0, md5_pkg::PAD_BYTE};
            else blk_r[wsel][8*bsel +: 8] <= md5_pkg::PAD_BYTE;
            pad_w_r <= wsel + 4'd1;
            if (wsel == 4'd15) begin
              extra_r <= pos >= 6'd56;
              state_r <= (pos >= 6'd56) ? ST_RND : ST_LEN;
              rnd_r <= '0;
              a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
            end
          end else begin
            blk_r[pad_w_r] <= '0;
            pad_w_r <= pad_w_r + 4'd1;
            if (pad_w_r == 4'd15) begin
              extra_r <= pos >= 6'd56;
              state_r <= (pos >= 6'd56) ? ST_RND : ST_LEN;
              rnd_r <= '0;
              a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
            end
          end
        end
        ST_LEN: begin
          blk_r[14] <= bits[31:0];
          blk_r[15] <= bits[63:32];
          final_r <= 1'b1;
          extra_r <= 1'b0;
          rnd_r <= '0;
          a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
          state_r <= ST_RND;
        end
        ST_RND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          ch_r[0] <= ch_r[0] + a_r; ch_r[1] <= ch_r[1] + b_r;
          ch_r[2] <= ch_r[2] + c_r; ch_r[3] <= ch_r[3] + d_r;
          if (final_r) state_r <= ST_OUT;
          else if (extra_r && pos == 6'd0) begin
            // full block ended on a last byte: pad a fresh block
            state_r <= ST_PAD;
          end else if (extra_r) begin
            for (int w = 0; w < 14; w++) blk_r[w] <= '0;
            state_r <= ST_LEN;
          end else state_r <= ST_IDLE;
        end
        ST_OUT: begin
          if (!obuf_v_r) begin
            obuf_v_r <= 1'b1;
            obuf_r <= '{digest_a: ch_r[0], digest_b: ch_r[1],
                        digest_c: ch_r[2], digest_d: ch_r[3]};
            cnt_r <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

### src/md5_message_digest_core.sv
// Top level of the MD5 digest core: config registers, front queue, back engine.
// Depends on md5_pkg, md5_stream_if, md5_front, md5_back.
//
//  channel | dir | payload                          | beat accepted when
//  in_     | in  | data_byte, has_byte, last        | in.valid & in.ready
//  out_    | out | digest_a..digest_d               | out.valid & out.ready
//  cfg_    | in  | index (3b), data (40b)           | cfg_valid & cfg_ready
//
// A byte beat is packed into the block; a full block also runs 64 rounds and the fold.
// Closing a message pads, writes the length and compresses.
// Rate is set by the single shared round unit, one round per cycle.
// Reset is synchronous; the chain reloads from the IV registers per message.
// The front queue keeps accepting while the engine or the output stalls, until full.
module md5_message_digest_core #(
  parameter int QueueDepth = md5_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  md5_stream_if.sink                    in_ch,
  md5_stream_if.source                  out_ch,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [md5_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [md5_pkg::PREFIX_W-1:0]  cfg_data
);
  logic [31:0] iv_a_r, iv_b_r, iv_c_r, iv_d_r;
  logic [39:0] prefix_r;
  logic        cmd_valid, cmd_ready;
  md5_pkg::cmd_t cmd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_a_r <= md5_pkg::IV_A_RST;
      iv_b_r <= md5_pkg::IV_B_RST;
      iv_c_r <= md5_pkg::IV_C_RST;
      iv_d_r <= md5_pkg::IV_D_RST;
      prefix_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        md5_pkg::REG_IV_A:   iv_a_r <= cfg_data[31:0];
        md5_pkg::REG_IV_B:   iv_b_r <= cfg_data[31:0];
        md5_pkg::REG_IV_C:   iv_c_r <= cfg_data[31:0];
        md5_pkg::REG_IV_D:   iv_d_r <= cfg_data[31:0];
        md5_pkg::REG_PREFIX: prefix_r <= cfg_data;
        default: ;
      endcase
    end
  end

  md5_front #(.QueueDepth(QueueDepth)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .cmd_valid, .cmd_ready, .cmd_data
  );

  md5_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_data,
    .iv_a(iv_a_r), .iv_b(iv_b_r), .iv_c(iv_c_r), .iv_d(iv_d_r),
    .prefix_bytes(prefix_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

`ifndef SYNTHESIS
  a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && !cmd_ready |=> cmd_valid) else $error("queue dropped a command");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
    else $error("digest changed while stalled");
`endif
endmodule
